/* rtl/bls_pkg.sv */
// Shared types, constants and the keyword table of the BASIC line shader.
`timescale 1ns / 1ps

package bls_pkg;

  localparam int COL_W      = 6;
  localparam int SHADE_W    = 2;
  localparam int KW_COUNT   = 25;
  localparam int KW_IDX_W   = 5;
  localparam int KW_MAX_LEN = 6;
  localparam int KW_LEN_W   = 3;
  localparam int KW_TXT_W   = 8 * KW_MAX_LEN;

  localparam logic [KW_IDX_W-1:0] KW_REM_IDX = 5'd11;

  localparam logic [SHADE_W-1:0] SHADE_DIM  = 2'd1;
  localparam logic [SHADE_W-1:0] SHADE_TEXT = 2'd2;
  localparam logic [SHADE_W-1:0] SHADE_KEY  = 2'd3;

  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_QUOTE  = 8'h22;
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;

  // Word buffer: the latest character sits in the low byte, so a word
  // compares directly against a right-justified keyword literal.
  typedef struct packed {
    logic [KW_TXT_W-1:0] txt;
    logic [KW_LEN_W-1:0] len;
  } word_t;

  function automatic word_t kw_entry(input logic [KW_IDX_W-1:0] idx);
    word_t e;
    e.txt = '0;
    e.len = '0;
    unique case (idx)
      5'd0:  begin e.txt = KW_TXT_W'("PRINT");  e.len = 3'd5; end
      5'd1:  begin e.txt = KW_TXT_W'("INPUT");  e.len = 3'd5; end
      5'd2:  begin e.txt = KW_TXT_W'("IF");     e.len = 3'd2; end
      5'd3:  begin e.txt = KW_TXT_W'("THEN");   e.len = 3'd4; end
      5'd4:  begin e.txt = KW_TXT_W'("GOTO");   e.len = 3'd4; end
      5'd5:  begin e.txt = KW_TXT_W'("GOSUB");  e.len = 3'd5; end
      5'd6:  begin e.txt = KW_TXT_W'("RETURN"); e.len = 3'd6; end
      5'd7:  begin e.txt = KW_TXT_W'("FOR");    e.len = 3'd3; end
      5'd8:  begin e.txt = KW_TXT_W'("TO");     e.len = 3'd2; end
      5'd9:  begin e.txt = KW_TXT_W'("NEXT");   e.len = 3'd4; end
      5'd10: begin e.txt = KW_TXT_W'("END");    e.len = 3'd3; end
      5'd11: begin e.txt = KW_TXT_W'("REM");    e.len = 3'd3; end
      5'd12: begin e.txt = KW_TXT_W'("CLS");    e.len = 3'd3; end
      5'd13: begin e.txt = KW_TXT_W'("PAUSE");  e.len = 3'd5; end
      5'd14: begin e.txt = KW_TXT_W'("LET");    e.len = 3'd3; end
      5'd15: begin e.txt = KW_TXT_W'("STEP");   e.len = 3'd4; end
      5'd16: begin e.txt = KW_TXT_W'("STOP");   e.len = 3'd4; end
      5'd17: begin e.txt = KW_TXT_W'("AND");    e.len = 3'd3; end
      5'd18: begin e.txt = KW_TXT_W'("OR");     e.len = 3'd2; end
      5'd19: begin e.txt = KW_TXT_W'("NOT");    e.len = 3'd3; end
      5'd20: begin e.txt = KW_TXT_W'("MOD");    e.len = 3'd3; end
      5'd21: begin e.txt = KW_TXT_W'("RND");    e.len = 3'd3; end
      5'd22: begin e.txt = KW_TXT_W'("ABS");    e.len = 3'd3; end
      5'd23: begin e.txt = KW_TXT_W'("SGN");    e.len = 3'd3; end
      5'd24: begin e.txt = KW_TXT_W'("JOY");    e.len = 3'd3; end
      default: begin e.txt = '0; e.len = '0; end
    endcase
    return e;
  endfunction

endpackage

/* rtl/bls_kw_unit.sv */
// Shared keyword compare unit: matches the word buffer against one table entry.
`timescale 1ns / 1ps

module bls_kw_unit (
  input  bls_pkg::word_t                word_i,
  input  logic [bls_pkg::KW_IDX_W-1:0]  kw_idx_i,
  output logic                          hit_o,
  output logic                          rem_o
);

  bls_pkg::word_t entry;

  always_comb begin
    entry = bls_pkg::kw_entry(kw_idx_i);
    hit_o = (word_i.len == entry.len) && (word_i.txt == entry.txt);
    rem_o = hit_o && (kw_idx_i == bls_pkg::KW_REM_IDX);
  end

endmodule

/* rtl/basic_line_syntax_shader_top.sv */
// Top level of the BASIC line shader: line store, scan sequencer and output stage.
`timescale 1ns / 1ps

// The block takes one line of BASIC text, LINE_COLUMNS characters, one
// character per input beat on char_code_i (in_valid_i / in_stall_o). While a
// line is being loaded, in_stall_o is low and one character is taken per
// cycle in which in_valid_i is high. After the last column the block stalls
// its input and scans the stored line: each column goes through a line memory
// read, then classification; every completed word is tried against the keyword
// table entries one at a time in the shared compare unit (up to 25), after
// which any column that ended it is read again unless the word was REM, and a
// keyword or comment is rewritten column by column. The results then leave as
// LINE_COLUMNS output beats (column_o, shade_o, line_done_o on out_valid_o /
// out_stall_i), each read from the shade memory and then loaded into the output
// register; line_done_o marks the final column. The output register holds its
// beat while out_stall_i is high; the block only moves on once the beat is
// taken, and the last beat of a line may wait while the next line is already
// loading. Reset clears the fill count, the sequencer and the output valid; the
// line and shade memories need no clearing because a whole line is written
// before any entry is read.

module basic_line_syntax_shader_top #(
  parameter int LINE_COLUMNS = 40
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [7:0]                      char_code_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [bls_pkg::COL_W-1:0]       column_o,
  output logic [bls_pkg::SHADE_W-1:0]     shade_o,
  output logic                            line_done_o
);

  localparam int CW = $clog2(LINE_COLUMNS);
  localparam logic [CW:0]   POS_END  = (CW+1)'(LINE_COLUMNS);
  localparam logic [CW-1:0] COL_LAST = CW'(LINE_COLUMNS - 1);
  localparam logic [bls_pkg::KW_IDX_W-1:0] KW_LAST = bls_pkg::KW_IDX_W'(bls_pkg::KW_COUNT - 1);

  typedef enum logic [2:0] {
    S_LOAD, S_SCAN_RD, S_SCAN_EV, S_CHECK, S_FILL, S_OUT_RD, S_OUT_LD
  } state_e;

  // Scanner context: what the characters seen so far on this line mean.
  typedef enum logic [2:0] {
    M_LEAD, M_LNUM, M_NORM, M_STR, M_WORD
  } mode_e;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_word_byte(input logic [7:0] c);
    return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z")) ||
           is_digit(c) || (c == bls_pkg::CHAR_DOLLAR);
  endfunction

  function automatic logic [7:0] fold_up(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) ? 8'(c - 8'd32) : c;
  endfunction

  // Memories.
  logic [7:0]                  line_mem  [LINE_COLUMNS];
  logic [bls_pkg::SHADE_W-1:0] shade_mem [LINE_COLUMNS];

  // Sequencer registers.
  state_e                        state_q, state_d;
  mode_e                         mode_q, mode_d;
  logic [CW-1:0]                 fill_q, fill_d;
  logic [CW:0]                   pos_q, pos_d;
  logic [CW-1:0]                 ws_q, ws_d;
  bls_pkg::word_t                word_q, word_d;
  logic [bls_pkg::KW_IDX_W-1:0]  kw_idx_q, kw_idx_d;
  logic [CW-1:0]                 fp_q, fp_d;
  logic [CW-1:0]                 fe_q, fe_d;
  logic                          rem_q, rem_d;
  logic [CW-1:0]                 oc_q, oc_d;
  logic                          out_valid_q, out_valid_d;
  logic [CW-1:0]                 col_q, col_d;
  logic [bls_pkg::SHADE_W-1:0]   shade_q, shade_d;
  logic                          done_q, done_d;

  // Registered memory read data.
  logic [7:0]                  lrd_q;
  logic [bls_pkg::SHADE_W-1:0] srd_q;

  // Memory port controls.
  logic                        lw_en, lrd_en, sw_en, srd_en;
  logic [CW-1:0]               sw_addr;
  logic [bls_pkg::SHADE_W-1:0] sw_data;

  logic       in_fire, out_fire, use_normal;
  logic       kw_hit, kw_rem;
  logic [7:0] ch;

  assign in_stall_o  = (state_q != S_LOAD);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_fire    = out_valid_q && !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign column_o    = bls_pkg::COL_W'(col_q);
  assign shade_o     = shade_q;
  assign line_done_o = done_q;
  assign ch          = lrd_q;

  bls_kw_unit u_kw (
    .word_i   (word_q),
    .kw_idx_i (kw_idx_q),
    .hit_o    (kw_hit),
    .rem_o    (kw_rem)
  );

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    fill_d      = fill_q;
    pos_d       = pos_q;
    ws_d        = ws_q;
    word_d      = word_q;
    kw_idx_d    = kw_idx_q;
    fp_d        = fp_q;
    fe_d        = fe_q;
    rem_d       = rem_q;
    oc_d        = oc_q;
    col_d       = col_q;
    shade_d     = shade_q;
    done_d      = done_q;
    out_valid_d = out_valid_q && !out_fire;
    lw_en       = 1'b0;
    lrd_en      = 1'b0;
    sw_en       = 1'b0;
    srd_en      = 1'b0;
    sw_addr     = pos_q[CW-1:0];
    sw_data     = bls_pkg::SHADE_TEXT;
    use_normal  = 1'b0;

    unique case (state_q)
      S_LOAD: begin
        if (in_fire) begin
          lw_en = 1'b1;
          if (fill_q == COL_LAST) begin
            fill_d  = '0;
            pos_d   = '0;
            mode_d  = M_LEAD;
            state_d = S_SCAN_RD;
          end else begin
            fill_d = fill_q + 1'b1;
          end
        end
      end

      S_SCAN_RD: begin
        if (pos_q == POS_END) begin
          if (mode_q == M_WORD) begin
            kw_idx_d = '0;
            state_d  = S_CHECK;
          end else begin
            oc_d    = '0;
            state_d = S_OUT_RD;
          end
        end else begin
          lrd_en  = 1'b1;
          state_d = S_SCAN_EV;
        end
      end

      S_SCAN_EV: begin
        state_d = S_SCAN_RD;
        unique case (mode_q)
          M_LEAD: begin
            if (ch == bls_pkg::CHAR_SPACE) begin
              sw_en = 1'b1;
              pos_d = pos_q + 1'b1;
            end else if (is_digit(ch)) begin
              sw_en   = 1'b1;
              sw_data = bls_pkg::SHADE_DIM;
              pos_d   = pos_q + 1'b1;
              mode_d  = M_LNUM;
            end else begin
              use_normal = 1'b1;
            end
          end
          M_LNUM: begin
            if (is_digit(ch)) begin
              sw_en   = 1'b1;
              sw_data = bls_pkg::SHADE_DIM;
              pos_d   = pos_q + 1'b1;
            end else begin
              use_normal = 1'b1;
            end
          end
          M_NORM: begin
            use_normal = 1'b1;
          end
          M_STR: begin
            sw_en   = 1'b1;
            sw_data = bls_pkg::SHADE_KEY;
            pos_d   = pos_q + 1'b1;
            if (ch == bls_pkg::CHAR_QUOTE) begin
              mode_d = M_NORM;
            end
          end
          M_WORD: begin
            if (is_word_byte(ch)) begin
              sw_en = 1'b1;
              pos_d = pos_q + 1'b1;
              if (word_q.len < bls_pkg::KW_LEN_W'(bls_pkg::KW_MAX_LEN)) begin
                word_d.txt = {word_q.txt[bls_pkg::KW_TXT_W-9:0], fold_up(ch)};
              end
              if (word_q.len != '1) begin
                word_d.len = word_q.len + 1'b1;
              end
            end else begin
              // Word ended; unless REM, the column is classified after the check.
              kw_idx_d = '0;
              state_d  = S_CHECK;
            end
          end
          default: begin
            use_normal = 1'b1;
          end
        endcase

        if (use_normal) begin
          sw_en = 1'b1;
          pos_d = pos_q + 1'b1;
          if (ch == bls_pkg::CHAR_QUOTE) begin
            sw_data = bls_pkg::SHADE_KEY;
            mode_d  = M_STR;
          end else if (is_word_byte(ch)) begin
            mode_d     = M_WORD;
            ws_d       = pos_q[CW-1:0];
            word_d.txt = {{(bls_pkg::KW_TXT_W-8){1'b0}}, fold_up(ch)};
            word_d.len = bls_pkg::KW_LEN_W'(1);
          end else begin
            mode_d = M_NORM;
          end
        end
      end

      S_CHECK: begin
        if (kw_hit) begin
          mode_d  = M_NORM;
          fp_d    = ws_q;
          rem_d   = kw_rem;
          state_d = S_FILL;
          if (kw_rem) begin
            fe_d = COL_LAST;
          end else begin
            fe_d = CW'({1'b0, ws_q} + (CW+1)'(word_q.len) - (CW+1)'(1));
          end
        end else if (kw_idx_q == KW_LAST) begin
          mode_d  = M_NORM;
          state_d = S_SCAN_RD;
        end else begin
          kw_idx_d = kw_idx_q + 1'b1;
        end
      end

      S_FILL: begin
        sw_en   = 1'b1;
        sw_addr = fp_q;
        sw_data = rem_q ? bls_pkg::SHADE_DIM : bls_pkg::SHADE_KEY;
        if (fp_q == fe_q) begin
          if (rem_q) begin
            oc_d    = '0;
            state_d = S_OUT_RD;
          end else begin
            state_d = S_SCAN_RD;
          end
        end else begin
          fp_d = fp_q + 1'b1;
        end
      end

      S_OUT_RD: begin
        srd_en  = 1'b1;
        state_d = S_OUT_LD;
      end

      S_OUT_LD: begin
        if (!out_valid_q || out_fire) begin
          out_valid_d = 1'b1;
          col_d       = oc_q;
          shade_d     = srd_q;
          done_d      = (oc_q == COL_LAST);
          if (oc_q == COL_LAST) begin
            oc_d    = '0;
            state_d = S_LOAD;
          end else begin
            oc_d    = oc_q + 1'b1;
            state_d = S_OUT_RD;
          end
        end
      end

      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      mode_q      <= M_LEAD;
      fill_q      <= '0;
      pos_q       <= '0;
      ws_q        <= '0;
      word_q      <= '0;
      kw_idx_q    <= '0;
      fp_q        <= '0;
      fe_q        <= '0;
      rem_q       <= 1'b0;
      oc_q        <= '0;
      out_valid_q <= 1'b0;
      col_q       <= '0;
      shade_q     <= '0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      fill_q      <= fill_d;
      pos_q       <= pos_d;
      ws_q        <= ws_d;
      word_q      <= word_d;
      kw_idx_q    <= kw_idx_d;
      fp_q        <= fp_d;
      fe_q        <= fe_d;
      rem_q       <= rem_d;
      oc_q        <= oc_d;
      out_valid_q <= out_valid_d;
      col_q       <= col_d;
      shade_q     <= shade_d;
      done_q      <= done_d;
    end
  end

  // Line memory: written while loading, read by the scanner.
  always_ff @(posedge clk_i) begin
    if (lw_en) begin
      line_mem[fill_q] <= char_code_i;
    end
    if (lrd_en) begin
      lrd_q <= line_mem[pos_q[CW-1:0]];
    end
  end

  // Shade memory: written by the scanner, read by the output stage.
  always_ff @(posedge clk_i) begin
    if (sw_en) begin
      shade_mem[sw_addr] <= sw_data;
    end
    if (srd_en) begin
      srd_q <= shade_mem[oc_q];
    end
  end

  // A partially loaded line only exists while the block is loading.
  a_fill_only_in_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q != '0) |-> (state_q == S_LOAD))
    else $error("partial line outside load state");

  // The final-column flag must sit on the last column.
  a_done_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && done_q) |-> (col_q == COL_LAST))
    else $error("line_done on wrong column");

  // A rewrite sweep never runs past its end column.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FILL) |-> (fp_q <= fe_q))
    else $error("fill pointer past end");

  // The keyword index stays inside the table.
  a_kw_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK) |-> (kw_idx_q <= KW_LAST))
    else $error("keyword index out of range");

  // An accepted non-final beat is followed by the next column in order.
  a_col_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && !done_q) |=> (oc_q == CW'($past(col_q) + 1'b1)) ||
                              (out_valid_q && col_q == CW'($past(col_q) + 1'b1)))
    else $error("column order broken");

endmodule
